@@ rtl/ffssa_pkg.sv @@
package ffssa_pkg;

	// Fixed field widths of the request and result.
	localparam int ROUTE_W = 32;
	localparam int REQ_W   = 7;
	localparam int ACT_W   = 7;
	localparam int START_W = 6;

	localparam int NUM_LINKS_DEF = 32;
	localparam int MAX_SLOTS_DEF = 64;

	// Slots examined per cycle by the first-fit scan.
	localparam int SCAN_W = 8;

	localparam logic [ACT_W-1:0] ACT_RESET = 7'd64;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic load;
		logic clear;
		logic gather_rd;
		logic scan;
		logic mark_rd;
		logic out_load;
	} ffssa_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic refuse;
		logic link_last;
		logic scan_hit;
		logic scan_last;
		logic out_free;
	} ffssa_sts_t;

endpackage

@@ rtl/ffssa_ctrl.sv @@
module ffssa_ctrl
	import ffssa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ffssa_sts_t sts,
	output ffssa_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_GATHER,
		ST_GWAIT,
		ST_SCAN,
		ST_MARK,
		ST_MWAIT,
		ST_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.clear     = (state_q == ST_DECIDE) && sts.is_clear;
		cmd.gather_rd = (state_q == ST_GATHER);
		cmd.scan      = (state_q == ST_SCAN);
		cmd.mark_rd   = (state_q == ST_MARK);
		cmd.out_load  = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.is_clear || sts.refuse) state_q <= ST_DONE;
					else state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					if (sts.link_last) state_q <= ST_GWAIT;
				end
				ST_GWAIT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_hit) state_q <= ST_MARK;
					else if (sts.scan_last) state_q <= ST_DONE;
				end
				ST_MARK: begin
					if (sts.link_last) state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/ffssa_dp.sv @@
module ffssa_dp
	import ffssa_pkg::*;
#(
	parameter int NUM_LINKS = NUM_LINKS_DEF,
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ACT_W-1:0]    cfg_wdata,
	input  logic                in_op,
	input  logic [ROUTE_W-1:0]  in_route_mask,
	input  logic [REQ_W-1:0]    in_slot_request,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_granted,
	output logic [START_W-1:0]  out_start_slot,
	input  ffssa_cmd_t          cmd,
	output ffssa_sts_t          sts
);

	// Links that a route mask can name.
	localparam int NLINK   = (NUM_LINKS < ROUTE_W) ? NUM_LINKS : ROUTE_W;
	localparam int LINK_W  = (NLINK > 1) ? $clog2(NLINK) : 1;
	localparam int ADDR_W  = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
	localparam int NCHUNK  = (MAX_SLOTS + SCAN_W - 1) / SCAN_W;
	localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int PAD_W   = NCHUNK * SCAN_W;

	// Occupancy store, one word per link; an entry whose valid bit is low reads as free.
	logic [MAX_SLOTS-1:0] mem_q [NUM_LINKS];
	logic [NUM_LINKS-1:0] valid_q;

	logic [ACT_W-1:0]     act_q;
	logic                 op_q;
	logic [NLINK-1:0]     mask_q;
	logic [REQ_W-1:0]     req_q;
	logic [LINK_W-1:0]    link_q;
	logic [MAX_SLOTS-1:0] busy_q;
	logic [CHUNK_W-1:0]   chunk_q;
	logic [REQ_W-1:0]     run_q;
	logic                 found_q;
	logic [START_W-1:0]   start_q;
	logic [START_W-1:0]   end_q;

	logic                 gath_s1;
	logic                 mark_s1;
	logic                 hit_s1;
	logic                 vld_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [MAX_SLOTS-1:0] rd_data_s1;

	logic                 out_valid_q;
	logic                 out_granted_q;
	logic [START_W-1:0]   out_start_q;

	logic [ADDR_W-1:0]    rd_addr;
	logic [ACT_W-1:0]     act_eff;
	logic [PAD_W-1:0]     busy_pad;
	logic [SCAN_W-1:0]    chunk_busy;
	logic [REQ_W-1:0]     scan_run;
	logic                 scan_hit;
	logic [START_W-1:0]   scan_end;
	logic [ACT_W-1:0]     slot_idx;
	logic [MAX_SLOTS-1:0] mark_bits;
	logic [MAX_SLOTS-1:0] old_word;

	assign rd_addr    = ADDR_W'(link_q);
	assign act_eff    = (act_q > ACT_W'(MAX_SLOTS)) ? ACT_W'(MAX_SLOTS) : act_q;
	assign busy_pad   = PAD_W'(busy_q);
	assign chunk_busy = busy_pad[chunk_q*SCAN_W +: SCAN_W];

	// One chunk of the first-fit scan: the run length carries over from the previous chunk.
	always_comb begin
		scan_run = run_q;
		scan_hit = 1'b0;
		scan_end = '0;
		slot_idx = '0;
		for (int j = 0; j < SCAN_W; j++) begin
			slot_idx = ACT_W'(chunk_q) * ACT_W'(SCAN_W) + ACT_W'(j);
			if (!scan_hit) begin
				if ((slot_idx < act_eff) && !chunk_busy[j]) begin
					scan_run = REQ_W'(scan_run + 1'b1);
					if (scan_run == req_q) begin
						scan_hit = 1'b1;
						scan_end = START_W'(slot_idx);
					end
				end else begin
					scan_run = '0;
				end
			end
		end
	end

	always_comb begin
		for (int s = 0; s < MAX_SLOTS; s++) begin
			mark_bits[s] = (START_W'(s) >= start_q) && (START_W'(s) <= end_q);
		end
	end

	assign old_word = vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		sts           = '0;
		sts.is_clear  = (op_q == OP_CLEAR);
		sts.refuse    = !(|mask_q) || (req_q == '0);
		sts.link_last = (link_q == LINK_W'(NLINK - 1));
		sts.scan_hit  = scan_hit;
		sts.scan_last = (chunk_q == CHUNK_W'(NCHUNK - 1));
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[rd_addr];
		if (mark_s1 && hit_s1) begin
			mem_q[addr_s1] <= old_word | mark_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (mark_s1 && hit_s1) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_RESET;
		end else if (cfg_we) begin
			act_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gath_s1     <= 1'b0;
			mark_s1     <= 1'b0;
			link_q      <= '0;
			chunk_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			gath_s1 <= cmd.gather_rd;
			mark_s1 <= cmd.mark_rd;
			if (cmd.load) begin
				link_q  <= '0;
				chunk_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.gather_rd || cmd.mark_rd) begin
					link_q <= sts.link_last ? '0 : LINK_W'(link_q + 1'b1);
				end
				if (cmd.scan) begin
					chunk_q <= CHUNK_W'(chunk_q + 1'b1);
					if (scan_hit) found_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= mask_q[link_q];
		vld_s1  <= valid_q[rd_addr];
		addr_s1 <= rd_addr;
		if (cmd.load) begin
			op_q   <= in_op;
			mask_q <= in_route_mask[NLINK-1:0];
			req_q  <= in_slot_request;
			busy_q <= '0;
			run_q  <= '0;
		end else begin
			if (gath_s1 && hit_s1) begin
				busy_q <= busy_q | old_word;
			end
			if (cmd.scan) begin
				run_q <= scan_run;
				if (scan_hit) begin
					end_q   <= scan_end;
					start_q <= START_W'(scan_end - START_W'(req_q) + 1'b1);
				end
			end
		end
		if (cmd.out_load) begin
			out_granted_q <= found_q;
			out_start_q   <= found_q ? start_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_granted    = out_granted_q;
	assign out_start_slot = out_start_q;

endmodule

@@ rtl/first_fit_spectrum_slot_allocator.sv @@
// First-fit spectrum slot allocator. One occupancy bitmap per link is held in a memory with one
// read and one write port. An allocate request ORs the bitmaps of the route's links, reading
// one link per cycle, then scans the active slots eight per cycle for the lowest free run as
// long as the request, and if one is found rewrites each route link with the run marked busy,
// again one link per cycle. Each pass over the memory visits L = min(NUM_LINKS, 32) links; a
// request refused by the scan skips the marking pass, and a clear or an empty/zero request
// skips all passes.
// Clear empties all bitmaps at once through per-link valid bits. A finished result sits in an
// output register, so a new request is accepted while it waits. Write active_slots only while
// the block is idle.
module first_fit_spectrum_slot_allocator
	import ffssa_pkg::*;
#(
	parameter int NUM_LINKS = NUM_LINKS_DEF,
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata,      // active_slots
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,   // route_mask[31:0], slot_request[38:32], zero
	input  logic [0:0]       s_axis_tuser,   // operation[0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // start_slot[5:0], zero
	output logic [0:0]       m_axis_tuser    // granted[0]
);

	ffssa_cmd_t         cmd;
	ffssa_sts_t         sts;
	logic [START_W-1:0] start_slot;

	ffssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffssa_dp #(
		.NUM_LINKS (NUM_LINKS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_op           (s_axis_tuser[0]),
		.in_route_mask   (s_axis_tdata[ROUTE_W-1:0]),
		.in_slot_request (s_axis_tdata[ROUTE_W+REQ_W-1:ROUTE_W]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_granted     (m_axis_tuser[0]),
		.out_start_slot  (start_slot),
		.cmd             (cmd),
		.sts             (sts)
	);

	assign m_axis_tdata = {2'b00, start_slot};

endmodule

@@ rtl/ffssa_chk.sv @@
module ffssa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// A refused or clear request always reports start slot zero.
	a_refused_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
		else $error("refused result with nonzero start slot");

	// Requests are handled one at a time: ready drops right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while another is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

endmodule

bind first_fit_spectrum_slot_allocator ffssa_chk u_ffssa_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
